>>> design/vlgd_pkg.sv
// ----------------------------------------------------------------------------
// Video line group decoder package
// Shared types, constants and decode functions for the line group decoder.
// ----------------------------------------------------------------------------
package vlgd_pkg;

  // Line geometry.
  localparam int LINE_PIXELS     = 768;
  localparam int GROUP_PIXELS    = 16;
  localparam int GROUPS_PER_LINE = (LINE_PIXELS + GROUP_PIXELS - 1) / GROUP_PIXELS;
  localparam int GROUP_CNT_W     = $clog2(GROUPS_PER_LINE + 1);

  // Payload storage.
  localparam int PAYLOAD_DEPTH = 8;
  localparam int PAYLOAD_IDX_W = $clog2(PAYLOAD_DEPTH);

  // Mode byte values as they appear on the stream.
  localparam logic [7:0] MODE_BYTE_BLANK = 8'h00;
  localparam logic [7:0] MODE_BYTE_1C    = 8'h01;
  localparam logic [7:0] MODE_BYTE_2C    = 8'h02;
  localparam logic [7:0] MODE_BYTE_BMP2X = 8'h03;
  localparam logic [7:0] MODE_BYTE_4C    = 8'h04;
  localparam logic [7:0] MODE_BYTE_BMP2  = 8'h06;
  localparam logic [7:0] MODE_BYTE_8C    = 8'h08;

  // Internal group mode; MODE_IDLE means a mode byte is awaited.
  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_1C    = 3'd1,
    MODE_2C    = 3'd2,
    MODE_BMP2X = 3'd3,
    MODE_4C    = 3'd4,
    MODE_BMP2  = 3'd5,
    MODE_8C    = 3'd6
  } group_mode_t;

  typedef struct packed {
    logic        known;
    group_mode_t mode;
  } mode_decode_t;

  // Translate a mode byte into an internal mode; known is low for invalid bytes.
  function automatic mode_decode_t decode_mode(input logic [7:0] mode_byte);
    mode_decode_t res;
    res.known = 1'b1;
    res.mode  = MODE_IDLE;
    unique case (mode_byte)
      MODE_BYTE_1C:    res.mode = MODE_1C;
      MODE_BYTE_2C:    res.mode = MODE_2C;
      MODE_BYTE_BMP2X: res.mode = MODE_BMP2X;
      MODE_BYTE_4C:    res.mode = MODE_4C;
      MODE_BYTE_BMP2:  res.mode = MODE_BMP2;
      MODE_BYTE_8C:    res.mode = MODE_8C;
      default:         res.known = 1'b0;
    endcase
    return res;
  endfunction

  // Number of payload bytes that follow the mode byte.
  function automatic logic [3:0] payload_len(input group_mode_t mode);
    logic [3:0] len;
    unique case (mode)
      MODE_1C:    len = 4'd1;
      MODE_2C:    len = 4'd2;
      MODE_BMP2X: len = 4'd3;
      MODE_4C:    len = 4'd4;
      MODE_BMP2:  len = 4'd6;
      MODE_8C:    len = 4'd8;
      default:    len = 4'd0;
    endcase
    return len;
  endfunction

endpackage

>>> design/video_line_group_decoder.sv
// ----------------------------------------------------------------------------
// Video line group decoder
// Turns an encoded byte stream into 16-pixel groups of 8-bit pixels.
// ----------------------------------------------------------------------------
// A group is registered on the output in the cycle after its last byte is taken.
// Throughput: one byte per cycle unless the output stalls or a zero fill runs; a
// group's pixels are formed in a single pass from the stored payload and the arriving
// byte, straight into the output register. An invalid mode byte yields one zero group
// per cycle, when the output is free, until the line ends; no byte is taken during it.
// Reset: synchronous, active high; waits for a line start, output register empty.
module video_line_group_decoder (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tuser,   // [0] line_start
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // [63:0] pixels_left, [127:64] pixels_right
  output logic         m_axis_tlast,   // last_group
  output logic         m_axis_tuser    // [0] bad_mode
);
  import vlgd_pkg::*;

  // Decoder state.
  group_mode_t              group_mode;
  logic [PAYLOAD_IDX_W-1:0] payload_count;
  logic [7:0]               payload_bytes [PAYLOAD_DEPTH];
  logic [GROUP_CNT_W-1:0]   groups_done;
  logic                     line_active;
  logic                     fill_active;

  // Next-state values.
  group_mode_t              group_mode_next;
  logic [PAYLOAD_IDX_W-1:0] payload_count_next;
  logic [GROUP_CNT_W-1:0]   groups_done_next;
  logic                     line_active_next;
  logic                     fill_active_next;

  logic                     out_free;
  logic                     in_beat;
  logic                     emit;
  logic                     emit_bad;
  logic                     emit_build;
  logic                     emit_last;
  logic                     pay_write;
  logic                     active_eff;
  group_mode_t              mode_eff;
  logic [PAYLOAD_IDX_W-1:0] count_eff;
  logic [GROUP_CNT_W-1:0]   done_eff;
  logic [3:0]               count_inc;
  mode_decode_t             dec;
  logic [7:0]               pay [PAYLOAD_DEPTH];
  logic [7:0]               px  [GROUP_PIXELS];
  logic [127:0]             px_flat;

  // Handshake: the output register frees when empty or being drained.
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !fill_active && out_free;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  // Line start restarts the line before this byte is looked at.
  assign active_eff = line_active || s_axis_tuser;
  assign mode_eff   = s_axis_tuser ? MODE_IDLE : group_mode;
  assign count_eff  = s_axis_tuser ? '0 : payload_count;
  assign done_eff   = s_axis_tuser ? '0 : groups_done;
  assign count_inc  = 4'(count_eff) + 4'd1;
  assign dec        = decode_mode(s_axis_tdata);

  // Payload view with the arriving byte merged in at its slot.
  always_comb begin
    for (int i = 0; i < PAYLOAD_DEPTH; i++) begin
      pay[i] = (PAYLOAD_IDX_W'(i) == count_eff) ? s_axis_tdata : payload_bytes[i];
    end
  end

  // Pixel formation for a completed group.
  always_comb begin
    for (int j = 0; j < GROUP_PIXELS; j++) begin
      px[j] = 8'h00;
    end
    unique case (mode_eff)
      MODE_1C: begin
        for (int j = 0; j < GROUP_PIXELS; j++) px[j] = pay[0];
      end
      MODE_2C: begin
        for (int j = 0; j < GROUP_PIXELS; j++) px[j] = pay[j / 8];
      end
      MODE_BMP2X: begin
        for (int j = 0; j < GROUP_PIXELS; j++) begin
          px[j] = pay[2][7 - j / 2] ? pay[1] : pay[0];
        end
      end
      MODE_4C: begin
        for (int j = 0; j < GROUP_PIXELS; j++) px[j] = pay[j / 4];
      end
      MODE_BMP2: begin
        for (int j = 0; j < 8; j++) begin
          px[j]     = pay[2][7 - j] ? pay[1] : pay[0];
          px[8 + j] = pay[5][7 - j] ? pay[4] : pay[3];
        end
      end
      MODE_8C: begin
        for (int j = 0; j < GROUP_PIXELS; j++) px[j] = pay[j / 2];
      end
      default: begin
      end
    endcase
    for (int j = 0; j < GROUP_PIXELS; j++) begin
      px_flat[8*j +: 8] = px[j];
    end
  end

  // Per-beat control: what this byte does to the state and whether a group leaves.
  always_comb begin
    group_mode_next    = group_mode;
    payload_count_next = payload_count;
    groups_done_next   = groups_done;
    line_active_next   = line_active;
    fill_active_next   = fill_active;
    emit               = 1'b0;
    emit_bad           = 1'b0;
    emit_build         = 1'b0;
    pay_write          = 1'b0;

    if (fill_active) begin
      // Zero fill after an invalid mode byte.
      emit     = out_free;
      emit_bad = 1'b1;
    end else if (in_beat) begin
      line_active_next   = active_eff;
      group_mode_next    = mode_eff;
      payload_count_next = count_eff;
      groups_done_next   = done_eff;
      if (active_eff) begin
        if (mode_eff == MODE_IDLE) begin
          if (s_axis_tdata == MODE_BYTE_BLANK) begin
            emit = 1'b1;
          end else if (dec.known) begin
            group_mode_next    = dec.mode;
            payload_count_next = '0;
          end else begin
            emit     = 1'b1;
            emit_bad = 1'b1;
          end
        end else begin
          pay_write = 1'b1;
          if (count_inc >= payload_len(mode_eff)) begin
            emit               = 1'b1;
            emit_build         = 1'b1;
            group_mode_next    = MODE_IDLE;
            payload_count_next = '0;
          end else begin
            payload_count_next = count_inc[PAYLOAD_IDX_W-1:0];
          end
        end
      end
    end

    // Group accounting for an emitted group.
    emit_last = (32'(done_eff) + 32'd1) >= 32'(GROUPS_PER_LINE);
    if (fill_active) begin
      emit_last = (32'(groups_done) + 32'd1) >= 32'(GROUPS_PER_LINE);
    end
    if (emit) begin
      if (emit_last) begin
        line_active_next = 1'b0;
        groups_done_next = '0;
        fill_active_next = 1'b0;
      end else begin
        groups_done_next = (fill_active ? groups_done : done_eff) + GROUP_CNT_W'(1);
        if (emit_bad) fill_active_next = 1'b1;
      end
    end
  end

  // Control state and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      group_mode    <= MODE_IDLE;
      payload_count <= '0;
      groups_done   <= '0;
      line_active   <= 1'b0;
      fill_active   <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      group_mode    <= group_mode_next;
      payload_count <= payload_count_next;
      groups_done   <= groups_done_next;
      line_active   <= line_active_next;
      fill_active   <= fill_active_next;
      if (out_free) m_axis_tvalid <= emit;
    end
  end

  // Payload store and output payload register.
  always_ff @(posedge clk) begin
    if (pay_write) payload_bytes[count_eff] <= s_axis_tdata;
    if (emit && out_free) begin
      m_axis_tdata <= emit_build ? px_flat : '0;
      m_axis_tlast <= emit_last;
      m_axis_tuser <= emit_bad;
    end
  end

  // No byte is taken while the zero fill runs.
  a_fill_blocks_input: assert property (@(posedge clk) disable iff (rst)
    fill_active |-> !s_axis_tready)
    else $error("byte accepted during zero fill");

  // A zero-fill group carries only zero pixels.
  a_bad_group_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("bad-mode group with non-zero pixels");

  // Fill only runs inside an active line.
  a_fill_in_line: assert property (@(posedge clk) disable iff (rst)
    fill_active |-> line_active)
    else $error("zero fill outside an active line");

  // The group count is clear whenever no line is active.
  a_idle_count_clear: assert property (@(posedge clk) disable iff (rst)
    !line_active |-> (groups_done == '0))
    else $error("group count left over after line end");

endmodule
